>>> hdl/ordered_dither_pixel_packer_macros.svh
// assertion macros for the ordered dither pixel packer
`ifndef ORDERED_DITHER_PIXEL_PACKER_MACROS_SVH
`define ORDERED_DITHER_PIXEL_PACKER_MACROS_SVH

// checked on every clock edge outside reset
`define ODP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ODP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/odp_pkg.sv
// types, constants and the channel quantizer for the ordered dither pixel packer
`default_nettype none

package odp_pkg;

	localparam int LevelW = 13;
	localparam int PosW   = 12;
	localparam int WordW  = 16;
	localparam int CfgW   = 8;

	localparam logic [2:0] FMT_RGB565   = 3'd0;
	localparam logic [2:0] FMT_RGBA5551 = 3'd1;
	localparam logic [2:0] FMT_ARGB1555 = 3'd2;
	localparam logic [2:0] FMT_RGB555   = 3'd3;
	localparam logic [2:0] FMT_RGBA4444 = 3'd4;
	localparam logic [2:0] FMT_ARGB4444 = 3'd5;
	localparam logic [2:0] FMT_RGB444   = 3'd6;

	localparam logic REG_PIXEL_FORMAT  = 1'b0;
	localparam logic REG_DITHER_AMOUNT = 1'b1;

	localparam logic [2:0]      PIXEL_FORMAT_RST  = FMT_RGB565;
	localparam logic [CfgW-1:0] DITHER_AMOUNT_RST = 8'd64;

	typedef enum logic [1:0] {
		DEPTH4 = 2'd0,
		DEPTH5 = 2'd1,
		DEPTH6 = 2'd2
	} depth_t;

	// 4 and 5 bit channels
	localparam logic signed [5:0] MAT_A [0:3][0:3] = '{
		'{ 6'sd16,  -6'sd4, -6'sd13,   6'sd1},
		'{ -6'sd8,  6'sd12,   6'sd5,  -6'sd9},
		'{-6'sd14,   6'sd2,  6'sd15,  -6'sd3},
		'{  6'sd6, -6'sd10,  -6'sd7,  6'sd11}
	};

	// 6 bit channel
	localparam logic signed [5:0] MAT_B [0:3][0:3] = '{
		'{ 6'sd16,   6'sd4,  6'sd13,   6'sd1},
		'{  6'sd8, -6'sd12,  -6'sd5,   6'sd9},
		'{ 6'sd14,  -6'sd2, -6'sd15,   6'sd3},
		'{  6'sd6,  6'sd10,   6'sd7,  6'sd11}
	};

	// floor(clamp(level/4096 - ea/(128*k), 0, 1) * m), exact
	function automatic logic [5:0] quantize(
		input logic [LevelW-1:0]        level,
		input logic signed [LevelW-1:0] ea,
		input depth_t                   depth
	);
		logic [9:0]          kval;
		logic [5:0]          mval;
		logic signed [31:0]  t;
		logic signed [31:0]  lim;
		logic [34:0]         u;
		logic [15:0]         w;
		logic [6:0]          q0;
		logic [9:0]          r;
		logic [5:0]          q;
		kval = 10'd128;
		mval = 6'd15;
		unique case (depth)
			DEPTH4: begin
				kval = 10'd128;
				mval = 6'd15;
			end
			DEPTH5: begin
				kval = 10'd255;
				mval = 6'd31;
			end
			DEPTH6: begin
				kval = 10'd511;
				mval = 6'd63;
			end
			default: begin
				kval = 10'd128;
				mval = 6'd15;
			end
		endcase
		t   = $signed((32'(level) * 32'(kval)) << 7) - (32'(ea) <<< 12);
		lim = $signed(32'(kval) << 19);
		u   = 35'(t[27:0]) * 35'(mval);
		w   = u[34:19];
		q0  = 7'd0;
		r   = 10'd0;
		q   = 6'd0;
		if (t <= 0) begin
			q = 6'd0;
		end else if (t >= lim) begin
			q = mval;
		end else begin
			unique case (depth)
				DEPTH4: begin
					q = 6'(w >> 7);
				end
				DEPTH5: begin
					q0 = 7'(w >> 8);
					r  = 10'(w[7:0]) + 10'(q0);
					q  = 6'(q0) + ((r >= 10'd255) ? 6'd1 : 6'd0);
				end
				DEPTH6: begin
					q0 = 7'(w >> 9);
					r  = 10'(w[8:0]) + 10'(q0);
					q  = 6'(q0) + ((r >= 10'd511) ? 6'd1 : 6'd0);
				end
				default: begin
					q = 6'd0;
				end
			endcase
		end
		return q;
	endfunction

endpackage

`default_nettype wire

>>> hdl/ordered_dither_pixel_packer.sv
// Ordered dither pixel packer: takes one pixel of four 13-bit channel levels
// (4096 = 1.0) with its screen position, subtracts a 4x4 ordered dither offset
// chosen by the low two bits of x and y and scaled by dither_amount/128, clamps
// to [0,1], truncates each channel to 4, 5 or 6 bits and packs a 16-bit word in
// the layout set by pixel_format. One pixel is taken every clock while the
// output is not stalled; each pixel passes through the input register and
// then the output register, with the quantizers and packing between them.
// Write the config registers only while no pixel is in flight.
`default_nettype none

`include "ordered_dither_pixel_packer_macros.svh"

module ordered_dither_pixel_packer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// red_level, green_level, blue_level, alpha_level, pixel_x, pixel_y, zero pad
	input  wire logic [79:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// packed_pixel
	output logic [15:0]      m_tdata
);

	logic [2:0]                  pixel_format_q;
	logic [odp_pkg::CfgW-1:0]    dither_amount_q;

	logic                        valid_s1;
	logic [odp_pkg::LevelW-1:0]  red_s1, green_s1, blue_s1, alpha_s1;
	logic [1:0]                  col_s1, row_s1;
	logic                        valid_s2;
	logic [odp_pkg::WordW-1:0]   word_s2;

	logic                        adv1;
	logic signed [13:0]          ea_full, eb_full;
	logic signed [odp_pkg::LevelW-1:0] ea, eb;
	logic                        abit;
	logic [5:0]                  qr5, qg5, qb5, qg6, qr4, qg4, qb4, qa4;
	logic [odp_pkg::WordW-1:0]   word;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q  <= odp_pkg::PIXEL_FORMAT_RST;
			dither_amount_q <= odp_pkg::DITHER_AMOUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				odp_pkg::REG_PIXEL_FORMAT:  pixel_format_q  <= cfg_data[2:0];
				odp_pkg::REG_DITHER_AMOUNT: dither_amount_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv1     = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			red_s1   <= s_tdata[12:0];
			green_s1 <= s_tdata[25:13];
			blue_s1  <= s_tdata[38:26];
			alpha_s1 <= s_tdata[51:39];
			col_s1   <= s_tdata[53:52];
			row_s1   <= s_tdata[65:64];
		end
	end

	// dither offsets and quantizers
	always_comb begin
		ea_full = odp_pkg::MAT_A[row_s1][col_s1] * $signed({1'b0, dither_amount_q});
		eb_full = odp_pkg::MAT_B[row_s1][col_s1] * $signed({1'b0, dither_amount_q});
		ea      = ea_full[odp_pkg::LevelW-1:0];
		eb      = eb_full[odp_pkg::LevelW-1:0];
		abit    = alpha_s1[12] | alpha_s1[11];

		qr5 = odp_pkg::quantize(red_s1,   ea, odp_pkg::DEPTH5);
		qg5 = odp_pkg::quantize(green_s1, ea, odp_pkg::DEPTH5);
		qb5 = odp_pkg::quantize(blue_s1,  ea, odp_pkg::DEPTH5);
		qg6 = odp_pkg::quantize(green_s1, eb, odp_pkg::DEPTH6);
		qr4 = odp_pkg::quantize(red_s1,   ea, odp_pkg::DEPTH4);
		qg4 = odp_pkg::quantize(green_s1, ea, odp_pkg::DEPTH4);
		qb4 = odp_pkg::quantize(blue_s1,  ea, odp_pkg::DEPTH4);
		qa4 = odp_pkg::quantize(alpha_s1, ea, odp_pkg::DEPTH4);

		unique case (pixel_format_q)
			odp_pkg::FMT_RGB565:   word = {qr5[4:0], qg6[5:0], qb5[4:0]};
			odp_pkg::FMT_RGBA5551: word = {qr5[4:0], qg5[4:0], qb5[4:0], abit};
			odp_pkg::FMT_ARGB1555: word = {abit, qr5[4:0], qg5[4:0], qb5[4:0]};
			odp_pkg::FMT_RGB555:   word = {1'b0, qr5[4:0], qg5[4:0], qb5[4:0]};
			odp_pkg::FMT_RGBA4444: word = {qr4[3:0], qg4[3:0], qb4[3:0], qa4[3:0]};
			odp_pkg::FMT_ARGB4444: word = {qa4[3:0], qr4[3:0], qg4[3:0], qb4[3:0]};
			odp_pkg::FMT_RGB444:   word = {4'd0, qr4[3:0], qg4[3:0], qb4[3:0]};
			default:               word = '0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && valid_s1) begin
			word_s2 <= word;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = word_s2;

	`ODP_ASSERT(a_out_from_s1, $rose(m_tvalid) |-> $past(valid_s1), "output item without a stage one item")
	`ODP_ASSERT(a_accept_fills_s1, (s_tvalid && s_tready) |=> valid_s1, "accepted item lost before stage one")
	`ODP_ASSERT(a_rgb444_top_zero, (m_tvalid && pixel_format_q == odp_pkg::FMT_RGB444) |-> (m_tdata[15:12] == 4'd0), "rgb444 top nibble not zero")
	`ODP_ASSERT(a_rgb555_top_zero, (m_tvalid && pixel_format_q == odp_pkg::FMT_RGB555) |-> !m_tdata[15], "rgb555 top bit not zero")
	`ODP_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> (!valid_s1 && !valid_s2) || $fell(arst_n), "pipeline not empty in reset")

endmodule

`default_nettype wire

>>> tb/ordered_dither_pixel_packer_check.sv
`timescale 1ns / 1ps
// checker for the pixel packer: predicts each packed pixel word and compares it with the output
module ordered_dither_pixel_packer_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// red_level, green_level, blue_level, alpha_level, pixel_x, pixel_y, zero pad
	input  logic [79:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// packed_pixel
	input  logic [15:0] m_tdata,
	output int          pending,
	output int          failures
);

	logic [2:0]  fmt;
	logic [7:0]  amt;
	logic [15:0] words_due [$];
	logic [15:0] want;

	initial begin
		pending = 0;
		failures = 0;
	end

	// 4 and 5 bit channels
	function automatic int offset_a(input logic [1:0] row, input logic [1:0] col);
		int tbl [16];
		tbl = '{16, -4, -13, 1, -8, 12, 5, -9, -14, 2, 15, -3, 6, -10, -7, 11};
		return tbl[{row, col}];
	endfunction

	// 6 bit channel
	function automatic int offset_b(input logic [1:0] row, input logic [1:0] col);
		int tbl [16];
		tbl = '{16, 4, 13, 1, 8, -12, -5, 9, 14, -2, -15, 3, 6, 10, 7, 11};
		return tbl[{row, col}];
	endfunction

	// floor(clamp(level/4096 - entry*amt/(128*scale), 0, 1) * levels), exact
	function automatic logic [5:0] dither_code(input logic [12:0] level, input int entry,
		input int levels, input int scale);
		longint num;
		longint den;
		longint q;
		num = longint'(level) * levels * 128 * scale
			- longint'(entry) * longint'(amt) * levels * 4096;
		den = longint'(4096) * 128 * scale;
		if (num <= 0) begin
			return 6'd0;
		end
		q = num / den;
		if (q > levels) begin
			q = levels;
		end
		return 6'(q);
	endfunction

	function automatic logic [15:0] dithered_word(input logic [79:0] data);
		logic [12:0] r, g, b, a;
		logic [1:0]  col, row;
		int          ea, eb;
		logic        abit;
		logic [5:0]  r5, g5, b5, g6, r4, g4, b4, a4;
		logic [15:0] word;
		r = data[12:0];
		g = data[25:13];
		b = data[38:26];
		a = data[51:39];
		col = data[53:52];
		row = data[65:64];
		ea = offset_a(row, col);
		eb = offset_b(row, col);
		abit = (a >= 13'd2048);
		r5 = dither_code(r, ea, 31, 255);
		g5 = dither_code(g, ea, 31, 255);
		b5 = dither_code(b, ea, 31, 255);
		g6 = dither_code(g, eb, 63, 511);
		r4 = dither_code(r, ea, 15, 128);
		g4 = dither_code(g, ea, 15, 128);
		b4 = dither_code(b, ea, 15, 128);
		a4 = dither_code(a, ea, 15, 128);
		case (fmt)
			odp_pkg::FMT_RGB565:   word = {r5[4:0], g6[5:0], b5[4:0]};
			odp_pkg::FMT_RGBA5551: word = {r5[4:0], g5[4:0], b5[4:0], abit};
			odp_pkg::FMT_ARGB1555: word = {abit, r5[4:0], g5[4:0], b5[4:0]};
			odp_pkg::FMT_RGB555:   word = {1'b0, r5[4:0], g5[4:0], b5[4:0]};
			odp_pkg::FMT_RGBA4444: word = {r4[3:0], g4[3:0], b4[3:0], a4[3:0]};
			odp_pkg::FMT_ARGB4444: word = {a4[3:0], r4[3:0], g4[3:0], b4[3:0]};
			odp_pkg::FMT_RGB444:   word = {4'd0, r4[3:0], g4[3:0], b4[3:0]};
			default:               word = 16'd0;
		endcase
		return word;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt = odp_pkg::PIXEL_FORMAT_RST;
			amt = odp_pkg::DITHER_AMOUNT_RST;
			words_due.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (words_due.size() == 0) begin
					$display("%0t: unexpected packed pixel, expected none, got %h",
						$time, m_tdata);
					failures = failures + 1;
				end else begin
					want = words_due.pop_front();
					if (m_tdata !== want) begin
						$display("%0t: packed pixel mismatch, expected %h, got %h",
							$time, want, m_tdata);
						failures = failures + 1;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				words_due.push_back(dithered_word(s_tdata));
			end
			if (cfg_we) begin
				if (cfg_index == odp_pkg::REG_PIXEL_FORMAT) begin
					fmt = cfg_data[2:0];
				end else begin
					amt = cfg_data;
				end
			end
			pending = words_due.size();
		end
	end

endmodule

>>> tb/ordered_dither_pixel_packer_test.sv
`timescale 1ns / 1ps
// test top for the pixel packer: clock, reset, stimulus, output stalls and the verdict
module ordered_dither_pixel_packer_test;

	localparam logic [2:0] FMT_UNUSED = 3'd7;
	localparam logic [7:0][2:0] FORMAT_ORDER = {FMT_UNUSED, odp_pkg::FMT_RGB444,
		odp_pkg::FMT_ARGB4444, odp_pkg::FMT_RGBA4444, odp_pkg::FMT_RGB555,
		odp_pkg::FMT_ARGB1555, odp_pkg::FMT_RGBA5551, odp_pkg::FMT_RGB565};
	localparam int ITEMS_PER_PHASE = 52;
	localparam int WATCHDOG_LIMIT = 1000;

	// packs into tdata from the lowest bit up: red, green, blue, alpha, x, y
	typedef struct packed {
		logic [11:0] y;
		logic [11:0] x;
		logic [12:0] a;
		logic [12:0] b;
		logic [12:0] g;
		logic [12:0] r;
	} pixel_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	int          pending;
	int          failures;
	int          idle_cycles;
	int          stall_mode;
	int          stall_left;

	ordered_dither_pixel_packer i_dut (.*);

	ordered_dither_pixel_packer_check i_check (.*);

	always #5 clk = ~clk;

	function automatic logic [12:0] random_level();
		case ($urandom_range(0, 9))
			0: return 13'd0;
			1: return 13'd4096;
			2: return 13'($urandom_range(4097, 8191));
			3: return 13'($urandom_range(0, 63) * 4096 / 63);
			4: return 13'($urandom_range(2040, 2056));
			default: return 13'($urandom_range(0, 4096));
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		p.r = random_level();
		p.g = random_level();
		p.b = random_level();
		p.a = random_level();
		p.x = 12'($urandom());
		p.y = 12'($urandom());
		return p;
	endfunction

	// zero and full scale, overrange, alpha threshold, strongest positive offset
	function automatic pixel_t corner_pixel(input int k);
		pixel_t p;
		case (k)
			0: p = '{y: 12'd0, x: 12'd0, a: 13'd2047, b: 13'd8191, g: 13'd4096, r: 13'd0};
			1: p = '{y: 12'd2, x: 12'd4093, a: 13'd2048, b: 13'd1, g: 13'd2048, r: 13'd4096};
			default: p = '{y: 12'd4095, x: 12'd4095, a: 13'd4096, b: 13'd4096, g: 13'd0,
				r: 13'd8191};
		endcase
		return p;
	endfunction

	task automatic send_pixel(input pixel_t p);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, p};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic send_random(input int count);
		int sent;
		int burst;
		int gap;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && sent < count; i++) begin
				send_pixel(random_pixel());
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				s_tdata <= 80'({$urandom(), $urandom(), $urandom()});
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// idle the input and let every pixel in flight come out
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		s_tdata <= 80'({$urandom(), $urandom(), $urandom()});
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(4, 60);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 7) != 0);
			default: m_tready <= ((stall_left % 7) < 3);
		endcase
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		logic [7:0] amount;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = odp_pkg::REG_PIXEL_FORMAT;
		cfg_data = 8'd0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// directed corners in every format, dither amount at its reset value
		for (int i = 0; i < 8; i++) begin
			if (i != 0) begin
				drain();
				write_reg(odp_pkg::REG_PIXEL_FORMAT, {5'd0, FORMAT_ORDER[i]});
			end
			for (int k = 0; k < 3; k++)
				send_pixel(corner_pixel(k));
		end

		for (int i = 0; i < 8; i++) begin
			for (int k = 0; k < 3; k++) begin
				case (k)
					0: amount = 8'd0;
					1: amount = 8'd255;
					default: amount = 8'($urandom_range(1, 254));
				endcase
				drain();
				// upper bits of a format write are ignored
				write_reg(odp_pkg::REG_PIXEL_FORMAT, {5'($urandom()), FORMAT_ORDER[i]});
				write_reg(odp_pkg::REG_DITHER_AMOUNT, amount);
				send_random(ITEMS_PER_PHASE);
			end
		end

		drain();
		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
